>>> hdl/rlde_pkg.sv
package rlde_pkg;

    localparam logic [1:0] REQ_PUSH   = 2'd0;
    localparam logic [1:0] REQ_FINISH = 2'd1;
    localparam logic [1:0] REQ_PULL   = 2'd2;

    localparam logic [7:0] CODE_ZERO_RUN  = 8'h40;
    localparam logic [7:0] CODE_REPEAT    = 8'h80;
    localparam logic [7:0] CODE_LITERAL   = 8'hC0;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_SLASH     = 8'h2F;

    localparam logic [5:0] REPEAT_START   = 6'd63;
    localparam logic [5:0] REPEAT_RESEND  = 6'd62;
    localparam logic [10:0] ROW_PIXELS_RESET = 11'd1056;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] pixel_byte;
    } req_item_t;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       out_last;
        logic       push_refused;
        logic [8:0] pending_bytes;
    } rsp_item_t;

endpackage

>>> hdl/raster_line_delta_rle_encoder.sv
// Raster line delta run-length encoder. Push requests store one byte of eight
// pixels in a line memory and answer directly. The push that completes a line
// of n bytes starts a row-end sequence driven by the shared read address of the
// line memories: a compare pass, and when the line difference changed or on the
// first line after reset or a finish, a copy pass plus the encoder, which scans
// the difference and reads back each byte emitted as a literal. A pull reads the
// code memory before its byte goes to the result register; finish and other
// requests go to the result register directly. There is no clearing pass after
// reset: stored lines read as zero until written.
module raster_line_delta_rle_encoder #(
    parameter int MAX_ROW_BYTES = 132,
    parameter int MAX_RUN       = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [10:0]         cfg_data,
    input  logic                req_valid,
    output logic                req_ready,
    input  rlde_pkg::req_item_t req_item,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output rlde_pkg::rsp_item_t rsp_item
);

    localparam int LA   = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int NW   = $clog2(MAX_ROW_BYTES + 1);
    localparam int CAP  = 2 * MAX_ROW_BYTES + 2;
    localparam int CA   = $clog2(CAP);
    localparam int CW   = $clog2(CAP + 1);
    localparam int QW   = $clog2(CAP + 6 + 1);
    localparam int RW   = $clog2(MAX_RUN + 1);
    localparam int PXW  = 12;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_PULL  = 5'd1;
    localparam logic [4:0] S_LE_RD = 5'd2;
    localparam logic [4:0] S_LE_WR = 5'd3;
    localparam logic [4:0] S_DEC   = 5'd4;
    localparam logic [4:0] S_CP_RD = 5'd5;
    localparam logic [4:0] S_CP_WR = 5'd6;
    localparam logic [4:0] S_L0    = 5'd7;
    localparam logic [4:0] S_L1    = 5'd8;
    localparam logic [4:0] S_L2    = 5'd9;
    localparam logic [4:0] S_LEND  = 5'd10;
    localparam logic [4:0] S_LC_RD = 5'd11;
    localparam logic [4:0] S_LC_WR = 5'd12;
    localparam logic [4:0] S_ALIT  = 5'd13;
    localparam logic [4:0] S_R0    = 5'd14;
    localparam logic [4:0] S_R1    = 5'd15;
    localparam logic [4:0] S_R2    = 5'd16;
    localparam logic [4:0] S_REND  = 5'd17;
    localparam logic [4:0] S_REND2 = 5'd18;
    localparam logic [4:0] S_DONE  = 5'd19;

    function automatic logic [11:0] bcd_inc(input logic [11:0] v);
        logic [11:0] r;
        r = v;
        if (v[3:0] == 4'd9)
        begin
            r[3:0] = 4'd0;
            if (v[7:4] == 4'd9)
            begin
                r[7:4]  = 4'd0;
                r[11:8] = v[11:8] + 4'd1;
            end
            else
            begin
                r[7:4] = v[7:4] + 4'd1;
            end
        end
        else
        begin
            r[3:0] = v[3:0] + 4'd1;
        end
        return r;
    endfunction

    logic [4:0]    state_reg, state_next;
    logic [10:0]   row_px_reg;
    logic [NW-1:0] pos_reg, pos_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] k_reg, k_next;
    logic [NW-1:0] bp_reg, bp_next;
    logic [RW-1:0] cnt_reg, cnt_next;
    logic [7:0]    last_reg, last_next;
    logic [7:0]    nxt_reg, nxt_next;
    logic          mism_reg, mism_next;
    logic [5:0]    lr_reg, lr_next;
    logic          first_reg, first_next;
    logic [CW-1:0] clen_reg, clen_next;
    logic [11:0]   bcd_reg, bcd_next;
    logic [QW-1:0] qlen_reg, qlen_next;
    logic [QW-1:0] emit_reg, emit_next;
    logic [7:0]    qrep_reg, qrep_next;
    logic          rsp_valid_reg;
    rlde_pkg::rsp_item_t rsp_item_reg;

    logic [MAX_ROW_BYTES-1:0] prev_vld_reg, prev_vld_next;
    logic [MAX_ROW_BYTES-1:0] sent_vld_reg, sent_vld_next;
    logic                     prev_vq_reg, sent_vq_reg;

    logic          line_re;
    logic [LA-1:0] line_raddr;
    logic          cur_we;
    logic [LA-1:0] cur_waddr;
    logic [7:0]    cur_wdata;
    logic          prev_we, sent_we;
    logic [7:0]    cur_q, prev_q, sent_q, code_q;
    logic          code_re;
    logic [CA-1:0] code_raddr;
    logic          put_en;
    logic [7:0]    put_val;
    logic          rsp_set;
    rlde_pkg::rsp_item_t rsp_val;

    logic [1:0]    ndig;
    logic [QW-1:0] hdr;
    logic [QW-1:0] pend;

    assign req_ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    assign ndig = (bcd_reg[11:8] != 4'd0) ? 2'd3 : ((bcd_reg[7:4] != 4'd0) ? 2'd2 : 2'd1);
    assign hdr  = QW'(ndig) + QW'(2);
    assign pend = qlen_reg - emit_reg;

    rlde_ram #(.DEPTH(MAX_ROW_BYTES), .WIDTH(8), .ADDR_W(LA)) u_cur (
        .clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
        .re(line_re), .raddr(line_raddr), .rdata(cur_q)
    );

    rlde_ram #(.DEPTH(MAX_ROW_BYTES), .WIDTH(8), .ADDR_W(LA)) u_prev (
        .clk(clk), .we(prev_we), .waddr(pos_reg[LA-1:0]), .wdata(cur_q),
        .re(line_re), .raddr(line_raddr), .rdata(prev_q)
    );

    rlde_ram #(.DEPTH(MAX_ROW_BYTES), .WIDTH(8), .ADDR_W(LA)) u_sent (
        .clk(clk), .we(sent_we), .waddr(pos_reg[LA-1:0]), .wdata(cur_q),
        .re(line_re), .raddr(line_raddr), .rdata(sent_q)
    );

    rlde_ram #(.DEPTH(CAP), .WIDTH(8), .ADDR_W(CA)) u_code (
        .clk(clk), .we(put_en && (clen_reg < CW'(CAP))), .waddr(clen_reg[CA-1:0]),
        .wdata(put_val), .re(code_re), .raddr(code_raddr), .rdata(code_q)
    );

    always_comb
    begin
        logic [PXW-1:0] px;
        logic [NW-1:0]  n;
        logic [NW-1:0]  bpc;
        logic [2:0]     pad;
        logic [7:0]     diff;
        logic [NW-1:0]  pos1;
        logic           cnt_lt_lim;
        logic           adj;
        logic [RW-1:0]  ua;
        logic [NW-1:0]  pa;
        logic [5:0]     lr1;
        logic [QW-1:0]  idx;
        logic [QW-1:0]  emit1;
        logic [1:0]     dsel;
        logic [7:0]     ob;

        state_next    = state_reg;
        pos_next      = pos_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        bp_next       = bp_reg;
        cnt_next      = cnt_reg;
        last_next     = last_reg;
        nxt_next      = nxt_reg;
        mism_next     = mism_reg;
        lr_next       = lr_reg;
        first_next    = first_reg;
        clen_next     = clen_reg;
        bcd_next      = bcd_reg;
        qlen_next     = qlen_reg;
        emit_next     = emit_reg;
        qrep_next     = qrep_reg;
        prev_vld_next = prev_vld_reg;
        sent_vld_next = sent_vld_reg;
        line_re       = 1'b0;
        line_raddr    = pos_reg[LA-1:0];
        cur_we        = 1'b0;
        cur_waddr     = pos_reg[LA-1:0];
        cur_wdata     = 8'd0;
        prev_we       = 1'b0;
        sent_we       = 1'b0;
        code_re       = 1'b0;
        code_raddr    = CA'(emit_reg - hdr);
        put_en        = 1'b0;
        put_val       = 8'd0;
        rsp_set       = 1'b0;
        rsp_val       = '0;

        px = {1'b0, row_px_reg};
        if (px == '0)
        begin
            px = PXW'(1);
        end
        if (px > PXW'(MAX_ROW_BYTES * 8))
        begin
            px = PXW'(MAX_ROW_BYTES * 8);
        end
        n   = NW'((px + PXW'(7)) >> 3);
        bpc = (bp_reg >= n) ? (n - NW'(1)) : bp_reg;
        pad = 3'(4'd8 - {1'b0, px[2:0]});

        diff       = (prev_vq_reg ? prev_q : 8'd0) ^ cur_q;
        pos1       = pos_reg + NW'(1);
        cnt_lt_lim = ({{NW{1'b0}}, cnt_reg} < {{RW{1'b0}}, n_reg})
                     && (cnt_reg < RW'(MAX_RUN));
        adj        = (cnt_reg != RW'(MAX_RUN)) && (pos_reg != n_reg);
        ua         = adj ? (cnt_reg - RW'(1)) : cnt_reg;
        pa         = adj ? (pos_reg - NW'(1)) : pos_reg;
        lr1        = lr_reg + 6'd1;
        idx        = emit_reg - QW'(1);
        emit1      = emit_reg + QW'(1);
        dsel       = 2'(QW'(ndig) - QW'(1) - idx);
        ob         = 8'd0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    rsp_set               = 1'b1;
                    rsp_val.pending_bytes = 9'(pend);
                    case (req_item.req_type)
                        rlde_pkg::REQ_PUSH:
                        begin
                            if (pend != '0)
                            begin
                                rsp_val.push_refused = 1'b1;
                            end
                            else if (bpc + NW'(1) == n)
                            begin
                                rsp_set   = 1'b0;
                                cur_we    = 1'b1;
                                cur_waddr = bpc[LA-1:0];
                                cur_wdata = req_item.pixel_byte & 8'(8'hFF << pad);
                                bp_next   = '0;
                                qlen_next = '0;
                                emit_next = '0;
                                n_next    = n;
                                pos_next  = '0;
                                mism_next = 1'b0;
                                state_next = S_LE_RD;
                            end
                            else
                            begin
                                cur_we    = 1'b1;
                                cur_waddr = bpc[LA-1:0];
                                cur_wdata = req_item.pixel_byte;
                                bp_next   = bpc + NW'(1);
                            end
                        end
                        rlde_pkg::REQ_FINISH:
                        begin
                            if (pend != '0)
                            begin
                                rsp_val.push_refused = 1'b1;
                            end
                            else
                            begin
                                qlen_next     = QW'(1);
                                emit_next     = '0;
                                qrep_next     = {2'b00, lr_reg};
                                lr_next       = rlde_pkg::REPEAT_START;
                                first_next    = 1'b1;
                                bp_next       = '0;
                                clen_next     = '0;
                                bcd_next      = 12'h001;
                                prev_vld_next = '0;
                                sent_vld_next = '0;
                                rsp_val.pending_bytes = 9'd1;
                            end
                        end
                        rlde_pkg::REQ_PULL:
                        begin
                            if (pend != '0)
                            begin
                                rsp_set    = 1'b0;
                                code_re    = 1'b1;
                                state_next = S_PULL;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_PULL:
            begin
                if (emit_reg == '0)
                begin
                    ob = qrep_reg;
                end
                else if (idx < QW'(ndig))
                begin
                    case (dsel)
                        2'd0:    ob = rlde_pkg::CHAR_ZERO | {4'd0, bcd_reg[3:0]};
                        2'd1:    ob = rlde_pkg::CHAR_ZERO | {4'd0, bcd_reg[7:4]};
                        default: ob = rlde_pkg::CHAR_ZERO | {4'd0, bcd_reg[11:8]};
                    endcase
                end
                else if (idx == QW'(ndig))
                begin
                    ob = rlde_pkg::CHAR_SLASH;
                end
                else
                begin
                    ob = code_q;
                end
                rsp_set          = 1'b1;
                rsp_val.out_valid = 1'b1;
                rsp_val.out_byte = ob;
                if (emit1 >= qlen_reg)
                begin
                    rsp_val.out_last      = 1'b1;
                    qlen_next             = '0;
                    emit_next             = '0;
                    rsp_val.pending_bytes = 9'd0;
                end
                else
                begin
                    emit_next             = emit1;
                    rsp_val.pending_bytes = 9'(qlen_reg - emit1);
                end
                state_next = S_IDLE;
            end
            S_LE_RD:
            begin
                line_re    = 1'b1;
                state_next = S_LE_WR;
            end
            S_LE_WR:
            begin
                if (diff != (sent_vq_reg ? sent_q : 8'd0))
                begin
                    mism_next = 1'b1;
                end
                prev_we   = 1'b1;
                prev_vld_next[pos_reg[LA-1:0]] = 1'b1;
                cur_we    = 1'b1;
                cur_wdata = diff;
                pos_next  = pos1;
                state_next = (pos1 == n_reg) ? S_DEC : S_LE_RD;
            end
            S_DEC:
            begin
                if (first_reg || mism_reg)
                begin
                    qrep_next  = {2'b00, lr_reg};
                    pos_next   = '0;
                    state_next = S_CP_RD;
                end
                else
                begin
                    rsp_set = 1'b1;
                    if (lr1 == rlde_pkg::REPEAT_RESEND)
                    begin
                        qrep_next = {2'b00, lr1};
                        qlen_next = hdr + QW'(clen_reg);
                        lr_next   = '0;
                        rsp_val.pending_bytes = 9'(hdr + QW'(clen_reg));
                    end
                    else
                    begin
                        lr_next = lr1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_CP_RD:
            begin
                line_re    = 1'b1;
                state_next = S_CP_WR;
            end
            S_CP_WR:
            begin
                sent_we  = 1'b1;
                sent_vld_next[pos_reg[LA-1:0]] = 1'b1;
                if (pos1 == n_reg)
                begin
                    pos_next   = '0;
                    clen_next  = '0;
                    bcd_next   = 12'h001;
                    state_next = S_L0;
                end
                else
                begin
                    pos_next   = pos1;
                    state_next = S_CP_RD;
                end
            end
            S_L0:
            begin
                line_re    = 1'b1;
                cnt_next   = '0;
                state_next = S_L1;
            end
            S_L1:
            begin
                last_next = cur_q;
                pos_next  = pos1;
                cnt_next  = cnt_reg + RW'(1);
                if (pos1 < n_reg)
                begin
                    line_re    = 1'b1;
                    line_raddr = pos1[LA-1:0];
                    state_next = S_L2;
                end
                else
                begin
                    state_next = S_LEND;
                end
            end
            S_L2:
            begin
                if ((last_reg != cur_q) && cnt_lt_lim)
                begin
                    last_next = cur_q;
                    pos_next  = pos1;
                    cnt_next  = cnt_reg + RW'(1);
                    if (pos1 < n_reg)
                    begin
                        line_re    = 1'b1;
                        line_raddr = pos1[LA-1:0];
                    end
                    else
                    begin
                        state_next = S_LEND;
                    end
                end
                else
                begin
                    state_next = S_LEND;
                end
            end
            S_LEND:
            begin
                pos_next = pa;
                cnt_next = ua;
                if (ua != '0)
                begin
                    put_en     = 1'b1;
                    put_val    = rlde_pkg::CODE_LITERAL | 8'(ua - RW'(1));
                    k_next     = pa - NW'(ua);
                    state_next = S_LC_RD;
                end
                else
                begin
                    state_next = S_ALIT;
                end
            end
            S_LC_RD:
            begin
                line_re    = 1'b1;
                line_raddr = k_reg[LA-1:0];
                state_next = S_LC_WR;
            end
            S_LC_WR:
            begin
                put_en  = 1'b1;
                put_val = cur_q;
                k_next  = k_reg + NW'(1);
                state_next = (k_reg + NW'(1) == pos_reg) ? S_ALIT : S_LC_RD;
            end
            S_ALIT:
            begin
                state_next = (pos_reg >= n_reg) ? S_DONE : S_R0;
            end
            S_R0:
            begin
                line_re    = 1'b1;
                cnt_next   = '0;
                state_next = S_R1;
            end
            S_R1:
            begin
                last_next = cur_q;
                pos_next  = pos1;
                cnt_next  = cnt_reg + RW'(1);
                if (pos1 < n_reg)
                begin
                    line_re    = 1'b1;
                    line_raddr = pos1[LA-1:0];
                    state_next = S_R2;
                end
                else
                begin
                    state_next = S_REND;
                end
            end
            S_R2:
            begin
                nxt_next = cur_q;
                if ((last_reg == cur_q) && cnt_lt_lim)
                begin
                    pos_next = pos1;
                    cnt_next = cnt_reg + RW'(1);
                    if (pos1 < n_reg)
                    begin
                        line_re    = 1'b1;
                        line_raddr = pos1[LA-1:0];
                    end
                    else
                    begin
                        state_next = S_REND;
                    end
                end
                else
                begin
                    state_next = S_REND;
                end
            end
            S_REND:
            begin
                if (cnt_reg > RW'(1))
                begin
                    put_en     = 1'b1;
                    state_next = S_REND2;
                    if (last_reg == 8'd0)
                    begin
                        if (({1'b0, pos_reg} + (NW + 1)'(1)) >= {1'b0, n_reg})
                        begin
                            put_val  = rlde_pkg::CODE_ZERO_RUN | 8'(cnt_reg - RW'(2));
                            nxt_next = 8'd0;
                        end
                        else
                        begin
                            put_val  = rlde_pkg::CODE_ZERO_RUN | 8'(cnt_reg - RW'(1));
                            pos_next = pos1;
                        end
                    end
                    else
                    begin
                        put_val  = rlde_pkg::CODE_REPEAT | 8'(cnt_reg - RW'(1));
                        nxt_next = last_reg;
                    end
                end
                else
                begin
                    pos_next   = pos_reg - NW'(1);
                    state_next = S_L0;
                end
            end
            S_REND2:
            begin
                put_en     = 1'b1;
                put_val    = nxt_reg;
                state_next = (pos_reg >= n_reg) ? S_DONE : S_L0;
            end
            S_DONE:
            begin
                qlen_next  = hdr + QW'(clen_reg);
                lr_next    = '0;
                first_next = 1'b0;
                rsp_set    = 1'b1;
                rsp_val.pending_bytes = 9'(hdr + QW'(clen_reg));
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (put_en && (clen_reg < CW'(CAP)))
        begin
            clen_next = clen_reg + CW'(1);
            bcd_next  = bcd_inc(bcd_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_px_reg    <= rlde_pkg::ROW_PIXELS_RESET;
            bp_reg        <= '0;
            lr_reg        <= rlde_pkg::REPEAT_START;
            first_reg     <= 1'b1;
            clen_reg      <= '0;
            bcd_reg       <= 12'h001;
            qlen_reg      <= '0;
            emit_reg      <= '0;
            prev_vld_reg  <= '0;
            sent_vld_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            if (cfg_we)
            begin
                row_px_reg <= cfg_data;
            end
            bp_reg       <= bp_next;
            lr_reg       <= lr_next;
            first_reg    <= first_next;
            clen_reg     <= clen_next;
            bcd_reg      <= bcd_next;
            qlen_reg     <= qlen_next;
            emit_reg     <= emit_next;
            prev_vld_reg <= prev_vld_next;
            sent_vld_reg <= sent_vld_next;
            if (rsp_set)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        n_reg    <= n_next;
        k_reg    <= k_next;
        cnt_reg  <= cnt_next;
        last_reg <= last_next;
        nxt_reg  <= nxt_next;
        mism_reg <= mism_next;
        qrep_reg <= qrep_next;
        if (line_re)
        begin
            prev_vq_reg <= prev_vld_reg[line_raddr];
            sent_vq_reg <= sent_vld_reg[line_raddr];
        end
        if (rsp_set)
        begin
            rsp_item_reg <= rsp_val;
        end
    end

endmodule

>>> hdl/rlde_ram.sv
module rlde_ram #(
    parameter int DEPTH  = 132,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> tb/rlde_checker.sv
`timescale 1ns / 100ps

module rlde_checker
    import rlde_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [10:0] cfg_data,
    input  logic      req_valid,
    input  logic      req_ready,
    input  req_item_t req_item,
    input  logic      rsp_valid,
    input  logic      rsp_ready,
    input  rsp_item_t rsp_item,
    output int        fail_count,
    output int        outstanding,
    output int        model_pending
);

    localparam int ROW_CAP  = 132;
    localparam int RUN_CAP  = 64;
    localparam int CODE_CAP = 2 * ROW_CAP + 2;
    localparam int Q_CAP    = CODE_CAP + 6;

    logic [10:0] width_px;
    logic [7:0]  prev_row [ROW_CAP];
    logic [7:0]  cur_row  [ROW_CAP];
    logic [7:0]  sent_diff[ROW_CAP];
    logic [7:0]  code_mem [CODE_CAP];
    logic [7:0]  out_mem  [Q_CAP];
    int          code_len;
    int          repeat_cnt;
    bit          first_line;
    int          col;
    int          q_len;
    int          q_pos;
    rsp_item_t   rsp_expected[$];

    function automatic void clear_image();
        for (int i = 0; i < ROW_CAP; i++)
        begin
            prev_row[i] = '0;
            cur_row[i] = '0;
            sent_diff[i] = '0;
        end
        code_len = 0;
        repeat_cnt = 63;
        first_line = 1'b1;
        col = 0;
    endfunction

    function automatic void q_put(int v);
        if (q_len < Q_CAP)
        begin
            out_mem[q_len] = v[7:0];
            q_len++;
        end
    endfunction

    function automatic void code_put(int v);
        if (code_len < CODE_CAP)
        begin
            code_mem[code_len] = v[7:0];
            code_len++;
        end
    endfunction

    function automatic void q_code();
        int len;
        len = code_len + 1;
        if (len >= 100)
            q_put(CHAR_ZERO + (len / 100) % 10);
        if (len >= 10)
            q_put(CHAR_ZERO + (len / 10) % 10);
        q_put(CHAR_ZERO + len % 10);
        q_put(CHAR_SLASH);
        for (int i = 0; i < code_len; i++)
            q_put(code_mem[i]);
    endfunction

    function automatic void build_codes(int n);
        int lim;
        int pos;
        int u;
        int e;
        logic [7:0] last;
        lim = (n < RUN_CAP) ? n : RUN_CAP;
        pos = 0;
        code_len = 0;
        forever
        begin
            u = 0;
            do
            begin
                last = sent_diff[pos];
                pos++;
                u++;
            end while (pos < n && last != sent_diff[pos] && u < lim);
            if (u != RUN_CAP && pos != n)
            begin
                u--;
                pos--;
            end
            if (u > 0)
            begin
                code_put(CODE_LITERAL | (u - 1));
                for (int i = pos - u; i < pos; i++)
                    code_put(sent_diff[i]);
            end
            if (pos >= n)
                break;
            e = 0;
            do
            begin
                last = sent_diff[pos];
                pos++;
                e++;
            end while (pos < n && last == sent_diff[pos] && e < lim);
            if (e > 1)
            begin
                if (last == 0)
                begin
                    if (pos + 1 >= n)
                    begin
                        code_put((e - 2) | CODE_ZERO_RUN);
                        code_put(sent_diff[pos - 1]);
                    end
                    else
                    begin
                        code_put((e - 1) | CODE_ZERO_RUN);
                        code_put(sent_diff[pos]);
                        pos++;
                    end
                end
                else
                begin
                    code_put((e - 1) | CODE_REPEAT);
                    code_put(last);
                end
            end
            else
                pos--;
            if (pos >= n)
                break;
        end
    endfunction

    function automatic void close_row(int n);
        logic [7:0] d[ROW_CAP];
        bit changed;
        changed = first_line;
        for (int i = 0; i < n; i++)
        begin
            d[i] = prev_row[i] ^ cur_row[i];
            if (d[i] != sent_diff[i])
                changed = 1'b1;
        end
        if (changed)
        begin
            q_put(repeat_cnt);
            for (int i = 0; i < n; i++)
                sent_diff[i] = d[i];
            build_codes(n);
            q_code();
            repeat_cnt = 0;
            first_line = 1'b0;
        end
        else
        begin
            repeat_cnt = (repeat_cnt + 1) & 63;
            if (repeat_cnt == REPEAT_RESEND)
            begin
                q_put(repeat_cnt);
                q_code();
                repeat_cnt = 0;
            end
        end
        for (int i = 0; i < n; i++)
            prev_row[i] = cur_row[i];
    endfunction

    function automatic rsp_item_t encoder_step(req_item_t it);
        rsp_item_t r;
        int px;
        int n;
        int pad;
        r = '0;
        if (it.req_type == REQ_PUSH || it.req_type == REQ_FINISH)
        begin
            if (q_len - q_pos != 0)
                r.push_refused = 1'b1;
            else if (it.req_type == REQ_PUSH)
            begin
                px = width_px;
                if (px == 0)
                    px = 1;
                if (px > ROW_CAP * 8)
                    px = ROW_CAP * 8;
                n = (px + 7) / 8;
                if (col >= n)
                    col = n - 1;
                if (col + 1 == n)
                begin
                    pad = n * 8 - px;
                    cur_row[col] = it.pixel_byte & (8'hFF << pad);
                    col = 0;
                    q_len = 0;
                    q_pos = 0;
                    close_row(n);
                end
                else
                begin
                    cur_row[col] = it.pixel_byte;
                    col++;
                end
            end
            else
            begin
                q_len = 0;
                q_pos = 0;
                q_put(repeat_cnt);
                clear_image();
            end
        end
        else if (it.req_type == REQ_PULL)
        begin
            if (q_len - q_pos != 0)
            begin
                r.out_valid = 1'b1;
                r.out_byte = out_mem[q_pos];
                q_pos++;
                if (q_pos >= q_len)
                begin
                    r.out_last = 1'b1;
                    q_len = 0;
                    q_pos = 0;
                end
            end
        end
        r.pending_bytes = q_len - q_pos;
        return r;
    endfunction

    initial
    begin
        width_px = ROW_PIXELS_RESET;
        clear_image();
        q_len = 0;
        q_pos = 0;
        fail_count = 0;
        outstanding = 0;
        model_pending = 0;
    end

    always @(posedge clk)
    begin
        rsp_item_t want;
        if (rst_n)
        begin
            if (cfg_we)
                width_px = cfg_data;
            if (req_valid && req_ready)
                rsp_expected.push_back(encoder_step(req_item));
            if (rsp_valid && rsp_ready)
            begin
                if (rsp_expected.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected item: actual %h", rsp_item);
                end
                else
                begin
                    want = rsp_expected.pop_front();
                    if (want.out_valid != rsp_item.out_valid
                        || want.out_byte != rsp_item.out_byte
                        || want.out_last != rsp_item.out_last
                        || want.push_refused != rsp_item.push_refused
                        || want.pending_bytes != rsp_item.pending_bytes)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected v%0d b%h l%0d r%0d p%0d, actual v%0d b%h l%0d r%0d p%0d",
                                     want.out_valid, want.out_byte, want.out_last,
                                     want.push_refused, want.pending_bytes,
                                     rsp_item.out_valid, rsp_item.out_byte,
                                     rsp_item.out_last, rsp_item.push_refused,
                                     rsp_item.pending_bytes);
                    end
                end
            end
            outstanding = rsp_expected.size();
            model_pending = q_len - q_pos;
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import rlde_pkg::*;

    localparam logic [1:0] REQ_NONE = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [10:0] cfg_data;
    logic        req_valid;
    logic        req_ready;
    req_item_t   req_item;
    logic        rsp_valid;
    logic        rsp_ready;
    rsp_item_t   rsp_item;
    int          fail_count;
    int          outstanding;
    int          model_pending;

    bit          hold_go;
    int          sent_items;
    int          row_bytes;
    logic [7:0]  last_row[132];

    raster_line_delta_rle_encoder i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_item (req_item),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_item (rsp_item)
    );

    rlde_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req_item     (req_item),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp_item     (rsp_item),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .model_pending(model_pending)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    initial
    begin
        #40ms;
        $display("tb: failure");
        $finish;
    end

    task automatic send_item(logic [1:0] t, logic [7:0] p);
        int r;
        int gap;
        req_item <= '{req_type: t, pixel_byte: p};
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        sent_items++;
        r = $urandom_range(0, 99);
        gap = (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic drain();
        int k;
        settle();
        k = model_pending + $urandom_range(0, 1);
        repeat (k) send_item(REQ_PULL, $urandom);
        settle();
    endtask

    task automatic set_width(int px);
        settle();
        repeat (12 * row_bytes + 60) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= px;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (px == 0)
            px = 1;
        if (px > 1056)
            px = 1056;
        row_bytes = (px + 7) / 8;
    endtask

    task automatic push_row(int kind);
        logic [7:0] b;
        logic [7:0] fill;
        fill = $urandom;
        for (int i = 0; i < row_bytes; i++)
        begin
            case (kind)
                0: b = $urandom;
                1: b = 8'h00;
                2: b = last_row[i];
                default:
                begin
                    if ($urandom_range(0, 5) == 0)
                        fill = ($urandom_range(0, 2) == 0) ? 8'h00 : $urandom;
                    b = fill;
                end
            endcase
            last_row[i] = b;
            send_item(REQ_PUSH, b);
        end
        drain();
    endtask

    initial
    begin
        int r;
        int px;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        req_valid = 1'b0;
        req_item = '0;
        hold_go = 1'b0;
        sent_items = 0;
        row_bytes = 132;
        for (int i = 0; i < 132; i++)
            last_row[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        set_width(8);
        send_item(REQ_PULL, 8'h00);
        send_item(REQ_NONE, 8'hFF);
        send_item(REQ_PUSH, 8'hFF);
        send_item(REQ_PUSH, 8'h00);
        send_item(REQ_FINISH, 8'h00);
        drain();
        send_item(REQ_PUSH, 8'h00);
        drain();
        send_item(REQ_PUSH, 8'h00);
        drain();
        set_width(3);
        send_item(REQ_PUSH, 8'hFF);
        drain();
        set_width(0);
        send_item(REQ_PUSH, 8'hA5);
        drain();
        set_width(24);
        send_item(REQ_PUSH, 8'h12);
        send_item(REQ_PUSH, 8'h34);
        set_width(8);
        send_item(REQ_PUSH, 8'h56);
        drain();
        send_item(REQ_FINISH, 8'hFF);
        send_item(REQ_FINISH, 8'h00);
        drain();

        // a long hold-off on the result side while items keep coming
        set_width(16);
        hold_go <= 1'b1;
        repeat (40) send_item(REQ_PULL, $urandom);
        settle();

        // random part
        while (sent_items < 800)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                px = 2047;
            else if (r < 12)
                px = 1056;
            else if (r < 16)
                px = $urandom_range(0, 1);
            else if (r < 40)
                px = 8 * $urandom_range(1, 8);
            else
                px = $urandom_range(1, 130);
            if (px > 1000 && $urandom_range(0, 3) != 0)
                px = $urandom_range(1, 40);
            set_width(px);
            r = $urandom_range(0, 9);
            if (r == 0 && row_bytes <= 4)
            begin
                push_row(0);
                repeat (64) push_row(1);
                repeat (63) push_row(2);
            end
            else
            begin
                repeat ($urandom_range(2, 8))
                begin
                    r = $urandom_range(0, 99);
                    if (r < 35)
                        push_row(0);
                    else if (r < 55)
                        push_row(3);
                    else if (r < 70)
                        push_row(2);
                    else if (r < 78)
                        push_row(1);
                    else if (r < 86)
                    begin
                        send_item(REQ_FINISH, $urandom);
                        send_item(REQ_PUSH, $urandom);
                        drain();
                    end
                    else if (r < 93)
                    begin
                        repeat ($urandom_range(1, 6))
                            send_item($urandom_range(0, 3), $urandom);
                        drain();
                    end
                    else
                    begin
                        for (int i = 0; i < row_bytes - 1; i++)
                            send_item(REQ_PUSH, $urandom);
                        send_item(REQ_PUSH, $urandom);
                        send_item(REQ_PUSH, $urandom);
                        send_item(REQ_FINISH, $urandom);
                        drain();
                    end
                end
            end
        end

        settle();
        repeat (12 * row_bytes + 100) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        bit held;
        int r;
        int d;
        held = 1'b0;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_go && !held)
            begin
                held = 1'b1;
                rsp_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    rsp_ready <= 1'b1;
                    d = $urandom_range(1, 30);
                end
                else if (r < 92)
                begin
                    rsp_ready <= 1'b0;
                    d = $urandom_range(1, 3);
                end
                else
                begin
                    rsp_ready <= 1'b0;
                    d = $urandom_range(10, 60);
                end
                repeat (d - 1) @(posedge clk);
            end
        end
    end

endmodule
